// ===== hw/rtl/golomb_encoder_assert.svh =====
// Assertion macros used by the Golomb encoder checker.
// No dependencies; include by bare file name.
`ifndef GOLOMB_ENCODER_ASSERT_SVH
`define GOLOMB_ENCODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is low
`define GOL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("golomb_encoder: assertion failed");

// Next-cycle implication, disabled while reset is low
`define GOL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("golomb_encoder: assertion failed");

`endif

// ===== hw/rtl/gol_pkg.sv =====
// Shared types and constants for the Golomb encoder.
// No dependencies; used by gol_ctrl, gol_datapath and golomb_encoder.
package gol_pkg;

  localparam int BYTE_BITS      = 8;
  localparam int FIELD_VAL_BITS = 9;   // r + c fits in 9 bits
  localparam int CNT_BITS       = 4;   // holds code_bits

  localparam logic [2:0] LAST_BIT_POS = 3'd7;

  // Configuration register indexes
  localparam logic [1:0] REG_DIVISOR   = 2'd0;
  localparam logic [1:0] REG_CODE_BITS = 2'd1;
  localparam logic [1:0] REG_THRESHOLD = 2'd2;

  // Reset values of the configuration registers
  localparam logic [7:0] DIVISOR_RST   = 8'd9;
  localparam logic [3:0] CODE_BITS_RST = 4'd4;
  localparam logic [7:0] THRESHOLD_RST = 8'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UNARY,
    ST_FIELD,
    ST_DRAIN,
    ST_FLUSH
  } gol_state_t;

  typedef struct packed {
    logic [7:0] divisor;
    logic [3:0] code_bits;
    logic [7:0] short_threshold;
  } cfg_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic unary_step;
    logic field_step;
    logic drain;
    logic flush;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic rem_ge;
    logic cnt_zero;
    logic pend_valid;
    logic fin;
    logic slot_free;
  } status_t;

endpackage

// ===== hw/rtl/gol_ctrl.sv =====
// Sequencing state machine of the Golomb encoder.
// Depends on gol_pkg for the state, command and status types.
module gol_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  gol_pkg::status_t sts,
  output gol_pkg::cmd_t    cmd,
  output logic             in_stall
);

  gol_pkg::gol_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gol_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gol_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gol_pkg::ST_UNARY;
      end
      gol_pkg::ST_UNARY: begin
        // terminating one bit ends the unary part
        if (sts.slot_free && !sts.rem_ge) state_nxt = gol_pkg::ST_FIELD;
      end
      gol_pkg::ST_FIELD: begin
        if (sts.cnt_zero) state_nxt = gol_pkg::ST_DRAIN;
      end
      gol_pkg::ST_DRAIN: begin
        if (!sts.pend_valid || sts.slot_free) begin
          state_nxt = sts.fin ? gol_pkg::ST_FLUSH : gol_pkg::ST_IDLE;
        end
      end
      gol_pkg::ST_FLUSH: begin
        if (sts.slot_free) state_nxt = gol_pkg::ST_IDLE;
      end
      default: state_nxt = gol_pkg::ST_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      gol_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      gol_pkg::ST_UNARY: cmd.unary_step = sts.slot_free;
      gol_pkg::ST_FIELD: cmd.field_step = sts.slot_free && !sts.cnt_zero;
      gol_pkg::ST_DRAIN: cmd.drain      = sts.slot_free && sts.pend_valid;
      gol_pkg::ST_FLUSH: cmd.flush      = sts.slot_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/gol_datapath.sv =====
// Datapath of the Golomb encoder: serial divider, field shifter, bit packer,
// one-byte hold stage and output register. Depends on gol_pkg.
module gol_datapath #(
  parameter int VALUE_BITS = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  gol_pkg::cfg_t cfg,
  input  gol_pkg::cmd_t cmd,
  output gol_pkg::status_t sts,
  input  logic [7:0]    in_value,
  input  logic          in_final_req,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_run_last
);

  localparam int CW = (VALUE_BITS > 8) ? VALUE_BITS : 8;

  logic [VALUE_BITS-1:0]              rem_r, rem_nxt;
  logic                               fin_r, fin_nxt;
  logic [gol_pkg::FIELD_VAL_BITS-1:0] fval_r, fval_nxt;
  logic [gol_pkg::CNT_BITS-1:0]       cnt_r, cnt_nxt;
  logic [gol_pkg::BYTE_BITS-1:0]      buf_r, buf_nxt;
  logic [2:0]                         fill_r, fill_nxt;
  logic [gol_pkg::BYTE_BITS-1:0]      pend_r, pend_nxt;
  logic                               pend_v_r, pend_v_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [gol_pkg::BYTE_BITS-1:0]      out_byte_r, out_byte_nxt;
  logic                               out_last_r, out_last_nxt;

  logic [15:0]                   val_ext;
  logic [7:0]                    m_eff;
  logic [CW-1:0]                 rem_ext, rem_sub;
  logic                          rem_ge;
  logic [7:0]                    r8;
  logic [8:0]                    r_plus_c;
  logic [gol_pkg::CNT_BITS-1:0]  pos;
  logic [15:0]                   fval_ext;
  logic                          field_bit;
  logic                          push_en, push_bit;
  logic [2:0]                    bit_idx;
  logic [gol_pkg::BYTE_BITS-1:0] pack;
  logic                          slot_free;

  // Divisor zero behaves as one
  assign m_eff    = (cfg.divisor == 8'd0) ? 8'd1 : cfg.divisor;
  assign val_ext  = 16'(in_value);
  assign rem_ext  = CW'(rem_r);
  assign rem_sub  = rem_ext - CW'(m_eff);
  assign rem_ge   = rem_ext >= CW'(m_eff);
  assign r8       = rem_ext[7:0];
  assign r_plus_c = {1'b0, r8} + {1'b0, cfg.short_threshold};

  // Field bits go out MSB first; positions above the field value read zero
  assign pos       = cnt_r - 4'd1;
  assign fval_ext  = 16'(fval_r);
  assign field_bit = fval_ext[pos];

  assign push_en   = cmd.unary_step | cmd.field_step;
  assign push_bit  = cmd.unary_step ? !rem_ge : field_bit;
  assign bit_idx   = gol_pkg::LAST_BIT_POS - fill_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    pack          = buf_r;
    pack[bit_idx] = push_bit;
  end

  // Next-value logic
  always_comb begin
    rem_nxt       = rem_r;
    fin_nxt       = fin_r;
    fval_nxt      = fval_r;
    cnt_nxt       = cnt_r;
    buf_nxt       = buf_r;
    fill_nxt      = fill_r;
    pend_nxt      = pend_r;
    pend_v_nxt    = pend_v_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;

    if (cmd.load) begin
      rem_nxt = val_ext[VALUE_BITS-1:0];
      fin_nxt = in_final_req;
    end

    // Serial division: subtract while the remainder reaches the divisor
    if (cmd.unary_step) begin
      if (rem_ge) begin
        rem_nxt = rem_sub[VALUE_BITS-1:0];
      end else if (m_eff == 8'd1) begin
        fval_nxt = '0;
        cnt_nxt  = '0;
      end else if (r8 < cfg.short_threshold) begin
        fval_nxt = {1'b0, r8};
        cnt_nxt  = (cfg.code_bits == 4'd0) ? 4'd0 : cfg.code_bits - 4'd1;
      end else begin
        fval_nxt = r_plus_c;
        cnt_nxt  = cfg.code_bits;
      end
    end

    if (cmd.field_step) cnt_nxt = pos;

    // Bit packer; a full byte waits in the hold stage until its successor
    // or the end of the item tells whether it is the last one
    if (push_en) begin
      if (fill_r == gol_pkg::LAST_BIT_POS) begin
        buf_nxt    = '0;
        fill_nxt   = '0;
        pend_nxt   = pack;
        pend_v_nxt = 1'b1;
        if (pend_v_r) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = pend_r;
          out_last_nxt  = 1'b0;
        end
      end else begin
        buf_nxt  = pack;
        fill_nxt = fill_r + 3'd1;
      end
    end

    if (cmd.drain) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = pend_r;
      out_last_nxt  = !fin_r;
      pend_v_nxt    = 1'b0;
    end

    // Final item: partial byte goes out, zero padded, even when empty
    if (cmd.flush) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = buf_r;
      out_last_nxt  = 1'b1;
      buf_nxt       = '0;
      fill_nxt      = '0;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_r       <= '0;
      fill_r      <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      buf_r       <= buf_nxt;
      fill_r      <= fill_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    rem_r      <= rem_nxt;
    fin_r      <= fin_nxt;
    fval_r     <= fval_nxt;
    cnt_r      <= cnt_nxt;
    pend_r     <= pend_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  always_comb begin
    sts.rem_ge     = rem_ge;
    sts.cnt_zero   = (cnt_r == '0);
    sts.pend_valid = pend_v_r;
    sts.fin        = fin_r;
    sts.slot_free  = slot_free;
  end

  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_run_last = out_last_r;

endmodule

// ===== hw/rtl/golomb_encoder.sv =====
// Golomb encoder top level: configuration registers, controller, datapath.
// Depends on gol_pkg, gol_ctrl and gol_datapath.
//
// Encodes one value at a time: a new value is accepted only once the item
// before it is finished, and a final_req item adds a flush step. The bit
// packer takes one code bit per cycle while the output is not stalled with a
// byte waiting, and the division is done as one compare and subtract per
// unary bit. Output bytes pass through a one-byte hold stage so the last byte
// of each item can be flagged, then an output register. Configuration may be
// written only while idle.
module golomb_encoder #(
  parameter int VALUE_BITS = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_value,
  input  logic       in_final_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last
);

  gol_pkg::cfg_t    cfg_r, cfg_nxt;
  gol_pkg::cmd_t    cmd;
  gol_pkg::status_t sts;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        gol_pkg::REG_DIVISOR:   cfg_nxt.divisor         = cfg_data;
        gol_pkg::REG_CODE_BITS: cfg_nxt.code_bits       = cfg_data[3:0];
        gol_pkg::REG_THRESHOLD: cfg_nxt.short_threshold = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.divisor         <= gol_pkg::DIVISOR_RST;
      cfg_r.code_bits       <= gol_pkg::CODE_BITS_RST;
      cfg_r.short_threshold <= gol_pkg::THRESHOLD_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  gol_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  gol_datapath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .cmd          (cmd),
    .sts          (sts),
    .in_value     (in_value),
    .in_final_req (in_final_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_run_last (out_run_last)
  );

endmodule

// ===== hw/rtl/gol_checker.sv =====
// Port-level checker for the Golomb encoder, bound to the top level.
// Depends on golomb_encoder_assert.svh and golomb_encoder.
`include "golomb_encoder_assert.svh"

module gol_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte,
  input logic       out_run_last
);

  // A stalled output transaction holds
  `GOL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_byte) && $stable(out_run_last))

  // One item at a time: busy right after an input transaction
  `GOL_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall)

  // When idle, a waiting byte can only be the last one of its item
  `GOL_ASSERT_IMPL(a_idle_last_byte, clk, rst_n, !in_stall && out_valid, out_run_last)

endmodule

bind golomb_encoder gol_checker u_gol_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_byte     (out_byte),
  .out_run_last (out_run_last)
);
